>>> hdl/lbc_pkg.sv
// ----------------------------------------------------------------------------
// lbc_pkg
// Shared codes, widths and payload layouts for the LED blink controller.
// ----------------------------------------------------------------------------
`default_nettype none

package lbc_pkg;

   // Command codes carried in the request tuser
   localparam logic [1:0] CMD_START = 2'd0;
   localparam logic [1:0] CMD_TICK  = 2'd1;
   localparam logic [1:0] CMD_SET   = 2'd2;

   // Pin modes
   localparam logic [1:0] MODE_OFF  = 2'd0;
   localparam logic [1:0] MODE_ON   = 2'd1;
   localparam logic [1:0] MODE_SLOW = 2'd2;
   localparam logic [1:0] MODE_FAST = 2'd3;

   // Register indexes on the csr port
   localparam int unsigned CSR_INDEX_BITS = 3;
   localparam logic [CSR_INDEX_BITS-1:0] REG_LED_MASK  = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_ON_LEVEL  = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_FUNC_MAP  = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] REG_COLOR_MAP = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] REG_MODE_MAP  = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] REG_SLOW      = 3'd5;
   localparam logic [CSR_INDEX_BITS-1:0] REG_FAST      = 3'd6;

   // Field widths
   localparam int unsigned MAX_PINS     = 16;
   localparam int unsigned FUNC_BITS    = 3;
   localparam int unsigned COLOR_BITS   = 2;
   localparam int unsigned MODE_BITS    = 2;
   localparam int unsigned TICK_BITS    = 16;
   localparam int unsigned CSR_DATA_BITS = 48;
   localparam logic [TICK_BITS-1:0] SLOW_RESET = 16'd10;
   localparam logic [TICK_BITS-1:0] FAST_RESET = 16'd2;

   // Request payload: function_sel, color_sel, mode_req, zero pad
   typedef struct packed {
      logic                  pad;
      logic [MODE_BITS-1:0]  mode_req;
      logic [COLOR_BITS-1:0] color_sel;
      logic [FUNC_BITS-1:0]  function_sel;
   } req_data_type;

   // Result payload: pin_levels low, changed_pins high
   typedef struct packed {
      logic [MAX_PINS-1:0] changed_pins;
      logic [MAX_PINS-1:0] pin_levels;
   } rsp_data_type;

endpackage

`default_nettype wire

>>> hdl/led_blink_controller.sv
// Path: an accepted request is held in the request register, and its result in the result register.
// Throughput: one request per cycle unless the result port stalls; the state update for all
// pins runs in a single pass between the request register and the result register.
// Reset (synchronous): all pins off and unlit, counters and periods zero,
// registers at their reset values, both pipeline slots empty.
// ----------------------------------------------------------------------------
// led_blink_controller
// Drives up to PINS LED pins through start, tick and set-mode commands and
// reports the pin levels and the pins that changed after each command.
// ----------------------------------------------------------------------------
`default_nettype none

module led_blink_controller #(
   parameter int unsigned PINS       = 16,
   parameter int unsigned COUNT_BITS = 16
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   // request channel
   input  wire logic                                 req_tvalid,
   output      logic                                 req_tready,
   input  wire lbc_pkg::req_data_type                req_tdata,  // function_sel, color_sel, mode_req
   input  wire logic [1:0]                           req_tuser,  // command
   // result channel
   output      logic                                 rsp_tvalid,
   input  wire logic                                 rsp_tready,
   output      lbc_pkg::rsp_data_type                rsp_tdata,  // pin_levels, changed_pins
   // register write channel
   input  wire logic                                 csr_valid,
   output      logic                                 csr_ready,
   input  wire logic [lbc_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  wire logic [lbc_pkg::CSR_DATA_BITS-1:0]    csr_data
);
   import lbc_pkg::*;

   localparam logic [PINS-1:0]       ONE_PIN   = {{(PINS-1){1'b0}}, 1'b1};
   localparam logic [COUNT_BITS-1:0] ONE_COUNT = {{(COUNT_BITS-1){1'b0}}, 1'b1};

   // Configuration registers
   logic [MAX_PINS-1:0]           led_mask_ff;
   logic [MAX_PINS-1:0]           on_level_ff;
   logic [FUNC_BITS*MAX_PINS-1:0] func_map_ff;
   logic [COLOR_BITS*MAX_PINS-1:0] color_map_ff;
   logic [MODE_BITS*MAX_PINS-1:0] mode_map_ff;
   logic [TICK_BITS-1:0]          slow_ticks_ff;
   logic [TICK_BITS-1:0]          fast_ticks_ff;

   // Request register
   logic         in_valid_ff;
   logic [1:0]   cmd_ff;
   req_data_type in_data_ff;

   // Per-pin state
   logic [MODE_BITS-1:0]  mode_ff   [PINS];
   logic [MODE_BITS-1:0]  mode_in   [PINS];
   logic [COUNT_BITS-1:0] count_ff  [PINS];
   logic [COUNT_BITS-1:0] count_in  [PINS];
   logic [COUNT_BITS-1:0] period_ff [PINS];
   logic [COUNT_BITS-1:0] period_in [PINS];
   logic [PINS-1:0]       lit_ff;
   logic [PINS-1:0]       lit_in;

   // Result register
   logic         rsp_valid_ff;
   logic         rsp_valid_in;
   rsp_data_type rsp_data_ff;
   rsp_data_type rsp_data_in;

   logic advance;

   // Periods truncated or extended to the counter width
   logic [31:0]           slow_ext;
   logic [31:0]           fast_ext;
   logic [COUNT_BITS-1:0] slow_period;
   logic [COUNT_BITS-1:0] fast_period;

   // Pair selection for set commands
   logic [PINS-1:0] led_pins;
   logic [PINS-1:0] match;
   logic [PINS-1:0] color_hit;
   logic [PINS-1:0] hit0;
   logic [PINS-1:0] rest;
   logic [PINS-1:0] hit1;
   logic [PINS-1:0] keep_sel;
   logic [PINS-1:0] off_sel;
   logic [PINS-1:0] apply_sel;
   logic            c0;
   logic            c1;
   logic            sel0_only;
   logic            sel1_only;
   logic            both_sel;

   logic [PINS-1:0]     levels;
   logic [PINS-1:0]     changed;
   logic [MAX_PINS-1:0] levels_wide;
   logic [MAX_PINS-1:0] changed_wide;

   assign csr_ready  = 1'b1;
   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign slow_ext    = {16'd0, slow_ticks_ff};
   assign fast_ext    = {16'd0, fast_ticks_ff};
   assign slow_period = slow_ext[COUNT_BITS-1:0];
   assign fast_period = fast_ext[COUNT_BITS-1:0];
   assign led_pins    = led_mask_ff[PINS-1:0];

   // Register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         led_mask_ff   <= '0;
         on_level_ff   <= '0;
         func_map_ff   <= '0;
         color_map_ff  <= '0;
         mode_map_ff   <= '0;
         slow_ticks_ff <= SLOW_RESET;
         fast_ticks_ff <= FAST_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            REG_LED_MASK:  led_mask_ff   <= csr_data[MAX_PINS-1:0];
            REG_ON_LEVEL:  on_level_ff   <= csr_data[MAX_PINS-1:0];
            REG_FUNC_MAP:  func_map_ff   <= csr_data[FUNC_BITS*MAX_PINS-1:0];
            REG_COLOR_MAP: color_map_ff  <= csr_data[COLOR_BITS*MAX_PINS-1:0];
            REG_MODE_MAP:  mode_map_ff   <= csr_data[MODE_BITS*MAX_PINS-1:0];
            REG_SLOW:      slow_ticks_ff <= csr_data[TICK_BITS-1:0];
            REG_FAST:      fast_ticks_ff <= csr_data[TICK_BITS-1:0];
            default: ;
         endcase
      end
   end

   // Capture a request
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
      if (req_tready && req_tvalid) begin
         cmd_ff     <= req_tuser;
         in_data_ff <= req_tdata;
      end
   end

   // Find the first two LED pins of the requested function and steer by color
   always_comb begin
      for (int p = 0; p < PINS; p++) begin
         match[p]     = led_pins[p]
                        && (func_map_ff[FUNC_BITS*p +: FUNC_BITS] == in_data_ff.function_sel);
         color_hit[p] = color_map_ff[COLOR_BITS*p +: COLOR_BITS] == in_data_ff.color_sel;
      end
      hit0      = match & (~match + ONE_PIN);
      rest      = match & ~hit0;
      hit1      = rest & (~rest + ONE_PIN);
      c0        = |(hit0 & color_hit);
      c1        = |(hit1 & color_hit);
      sel0_only = c0 && !c1 && (rest != '0);
      sel1_only = c1 && !c0;
      both_sel  = (rest != '0) && !sel0_only && !sel1_only;
      if ((rest == '0) || sel0_only) begin
         keep_sel = hit0;
      end else if (sel1_only) begin
         keep_sel = hit1;
      end else begin
         keep_sel = '0;
      end
      if (sel0_only) begin
         off_sel = hit1;
      end else if (sel1_only) begin
         off_sel = hit0;
      end else begin
         off_sel = '0;
      end
      for (int p = 0; p < PINS; p++) begin
         apply_sel[p] = (keep_sel[p] && (mode_ff[p] != in_data_ff.mode_req))
                        || (both_sel && (hit0[p] || hit1[p]));
      end
   end

   // Next state of every pin
   always_comb begin
      logic [MODE_BITS-1:0] dm;
      dm = MODE_OFF;
      for (int p = 0; p < PINS; p++) begin
         mode_in[p]   = mode_ff[p];
         count_in[p]  = count_ff[p];
         period_in[p] = period_ff[p];
         lit_in[p]    = lit_ff[p];
         if (advance && led_pins[p]) begin
            case (cmd_ff)
               CMD_START: begin
                  dm         = mode_map_ff[MODE_BITS*p +: MODE_BITS];
                  mode_in[p] = dm;
                  lit_in[p]  = dm != MODE_OFF;
                  if (dm == MODE_SLOW) begin
                     count_in[p]  = '0;
                     period_in[p] = slow_period;
                  end else if (dm == MODE_FAST) begin
                     count_in[p]  = '0;
                     period_in[p] = fast_period;
                  end
               end
               CMD_TICK: begin
                  if (mode_ff[p] == MODE_ON) begin
                     lit_in[p] = 1'b1;
                  end else if (mode_ff[p] == MODE_OFF) begin
                     lit_in[p] = 1'b0;
                  end else if (count_ff[p] < period_ff[p]) begin
                     count_in[p] = count_ff[p] + ONE_COUNT;
                  end else begin
                     lit_in[p]   = !lit_ff[p];
                     count_in[p] = '0;
                  end
               end
               CMD_SET: begin
                  if (apply_sel[p]) begin
                     mode_in[p]  = in_data_ff.mode_req;
                     count_in[p] = '0;
                     if (in_data_ff.mode_req == MODE_SLOW) begin
                        period_in[p] = slow_period;
                     end else if (in_data_ff.mode_req == MODE_FAST) begin
                        period_in[p] = fast_period;
                     end
                  end else if (off_sel[p]) begin
                     mode_in[p] = MODE_OFF;
                  end
               end
               default: ;
            endcase
         end
      end
   end

   // Build the result
   always_comb begin
      levels       = led_pins & ~(on_level_ff[PINS-1:0] ^ lit_in);
      changed      = led_pins & (lit_ff ^ lit_in);
      levels_wide  = '0;
      changed_wide = '0;
      levels_wide[PINS-1:0]  = levels;
      changed_wide[PINS-1:0] = changed;
      rsp_data_in.pin_levels   = levels_wide;
      rsp_data_in.changed_pins = changed_wide;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Hold pin state
   always_ff @(posedge clock) begin
      if (reset) begin
         lit_ff <= '0;
         for (int p = 0; p < PINS; p++) begin
            mode_ff[p]   <= MODE_OFF;
            count_ff[p]  <= '0;
            period_ff[p] <= '0;
         end
      end else begin
         lit_ff <= lit_in;
         for (int p = 0; p < PINS; p++) begin
            mode_ff[p]   <= mode_in[p];
            count_ff[p]  <= count_in[p];
            period_ff[p] <= period_in[p];
         end
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule

`default_nettype wire

>>> hdl/lbc_checker.sv
// ----------------------------------------------------------------------------
// lbc_checker
// Port-level checks for the LED blink controller, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module lbc_checker #(
   parameter int unsigned PINS = 16
) (
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  req_tready,
   input wire logic                  rsp_tvalid,
   input wire logic                  rsp_tready,
   input wire lbc_pkg::rsp_data_type rsp_tdata
);
   import lbc_pkg::*;

   localparam logic [MAX_PINS-1:0] UPPER_PINS = ~((MAX_PINS)'((64'd1 << PINS) - 64'd1));

   // Reset empties the result register
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // A stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

   // An empty result slot never blocks requests
   assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("request blocked with empty result slot");

   // Pins beyond PINS stay low and unchanged
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ((rsp_tdata.pin_levels & UPPER_PINS) == '0)
                     && ((rsp_tdata.changed_pins & UPPER_PINS) == '0))
      else $error("unused pin reported");

endmodule

bind led_blink_controller lbc_checker #(.PINS(PINS)) u_lbc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire
